[rtl/core/hrlc_pkg.sv]
// shared constants, types and name tables for the http request line checker
// no dependencies; used by every module under rtl/core

package hrlc_pkg;

    // sizing
    localparam int MAX_METHOD_CHARS = 7;
    localparam int URL_COUNT_BITS   = 16;

    localparam int METHOD_CNT_W  = $clog2(MAX_METHOD_CHARS + 1);
    localparam int METHOD_BUF_W  = MAX_METHOD_CHARS * 8;
    localparam int NUM_METHODS   = 9;
    localparam int NAME_BYTES    = 7;   // longest supported method name
    localparam int VERSION_LEN   = 8;
    localparam int VERSION_BUF_W = (VERSION_LEN - 1) * 8;
    localparam int NUM_VERSIONS  = 3;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // parser phases
    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_GAP1    = 3'd1;
    localparam logic [2:0] PH_URL     = 3'd2;
    localparam logic [2:0] PH_GAP2    = 3'd3;
    localparam logic [2:0] PH_VERSION = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    // verdict codes
    localparam logic [1:0] VERDICT_OK         = 2'd0;
    localparam logic [1:0] VERDICT_BAD_METHOD = 2'd1;
    localparam logic [1:0] VERDICT_BAD_REQ    = 2'd2;

    // method names, right aligned: last char in the low byte
    localparam logic [63:0] METHOD_STR [NUM_METHODS] = '{
        64'("GET"), 64'("HEAD"), 64'("POST"), 64'("PUT"), 64'("DELETE"),
        64'("CONNECT"), 64'("OPTIONS"), 64'("TRACE"), 64'("PATCH")
    };
    localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
        4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5
    };

    localparam logic [63:0] VERSION_STR [NUM_VERSIONS] = '{
        64'("HTTP/1.1"), 64'("HTTP/1.0"), 64'("HTTP/0.9")
    };

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic        url_too_long;
        logic [15:0] url_len;
        logic [1:0]  version_code;
        logic [3:0]  method_code;
        logic [1:0]  verdict;
    } result_t;

endpackage

[rtl/core/hrlc_in_stage.sv]
// input register for request bytes
// depends on hrlc_pkg

module hrlc_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] byte_in
    input  logic                s_tlast,   // last_byte
    input  logic                take,
    output logic                item_valid,
    output hrlc_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    hrlc_pkg::item_t item_reg;

    // room when empty or when the held item leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tvalid ? 1'b1 : (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.byte_in   <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/core/hrlc_parse.sv]
// request line parser: phase state, method and version buffers, url counter
// depends on hrlc_pkg

module hrlc_parse
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  hrlc_pkg::item_t     item,
    output logic                give,
    output hrlc_pkg::result_t   res
);

    logic [2:0]                             phase_reg, phase_next;
    logic [hrlc_pkg::METHOD_BUF_W-1:0]      mchars_reg, mchars_next;
    logic [hrlc_pkg::METHOD_CNT_W-1:0]      mcount_reg, mcount_next;
    logic [hrlc_pkg::VERSION_BUF_W-1:0]     vchars_reg, vchars_next;
    logic [2:0]                             vcount_reg, vcount_next;
    logic [hrlc_pkg::URL_COUNT_BITS-1:0]    url_reg, url_next;
    logic [3:0]                             found_reg, found_next;

    logic       method_hit;
    logic [3:0] method_code;
    logic       version_hit;
    logic [1:0] version_code;
    logic [1:0] verdict;
    logic [1:0] ver_out;
    logic       is_space;
    logic       method_bad;

    localparam logic [hrlc_pkg::URL_COUNT_BITS-1:0] URL_MAX = '1;

    // method lookup over the stored name bytes, low byte is the newest
    always_comb
    begin
        method_hit  = 1'b0;
        method_code = 4'd0;
        for (int k = 0; k < hrlc_pkg::NUM_METHODS; k++)
        begin
            logic ok;
            ok = (mcount_reg == hrlc_pkg::METHOD_CNT_W'(hrlc_pkg::METHOD_LEN[k]));
            for (int i = 0; i < hrlc_pkg::NAME_BYTES; i++)
            begin
                if (i < int'(hrlc_pkg::METHOD_LEN[k]) &&
                    mchars_reg[8*i +: 8] != hrlc_pkg::METHOD_STR[k][8*i +: 8])
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                method_hit  = 1'b1;
                method_code = 4'(k);
            end
        end
    end

    // version lookup: seven stored bytes plus the one arriving now
    always_comb
    begin
        version_hit  = 1'b0;
        version_code = 2'd0;
        for (int k = hrlc_pkg::NUM_VERSIONS - 1; k >= 0; k--)
        begin
            if ({vchars_reg, item.byte_in} == hrlc_pkg::VERSION_STR[k])
            begin
                version_hit  = 1'b1;
                version_code = 2'(k);
            end
        end
    end

    assign is_space = (item.byte_in == hrlc_pkg::CHAR_SPACE);

    always_comb
    begin
        phase_next  = phase_reg;
        mchars_next = mchars_reg;
        mcount_next = mcount_reg;
        vchars_next = vchars_reg;
        vcount_next = vcount_reg;
        url_next    = url_reg;
        found_next  = found_reg;
        give        = 1'b0;
        verdict     = hrlc_pkg::VERDICT_OK;
        ver_out     = 2'd0;

        case (phase_reg)
            hrlc_pkg::PH_METHOD:
            begin
                if (is_space)
                begin
                    if (method_hit)
                    begin
                        found_next = method_code;
                        phase_next = hrlc_pkg::PH_GAP1;
                    end
                    else
                    begin
                        give    = 1'b1;
                        verdict = hrlc_pkg::VERDICT_BAD_METHOD;
                    end
                end
                else if (mcount_reg ==
                         hrlc_pkg::METHOD_CNT_W'(hrlc_pkg::MAX_METHOD_CHARS))
                begin
                    give    = 1'b1;
                    verdict = hrlc_pkg::VERDICT_BAD_METHOD;
                end
                else
                begin
                    mchars_next = {mchars_reg[hrlc_pkg::METHOD_BUF_W-9:0], item.byte_in};
                    mcount_next = mcount_reg + 1'b1;
                end
            end
            hrlc_pkg::PH_GAP1:
            begin
                if (!is_space)
                begin
                    url_next   = hrlc_pkg::URL_COUNT_BITS'(1);
                    phase_next = hrlc_pkg::PH_URL;
                end
            end
            hrlc_pkg::PH_URL:
            begin
                if (is_space)
                begin
                    phase_next = hrlc_pkg::PH_GAP2;
                end
                else if (url_reg != URL_MAX)
                begin
                    url_next = url_reg + 1'b1;
                end
            end
            hrlc_pkg::PH_GAP2:
            begin
                if (!is_space)
                begin
                    vchars_next = {vchars_reg[hrlc_pkg::VERSION_BUF_W-9:0], item.byte_in};
                    vcount_next = 3'd1;
                    phase_next  = hrlc_pkg::PH_VERSION;
                end
            end
            hrlc_pkg::PH_VERSION:
            begin
                if (vcount_reg == 3'd7)
                begin
                    give = 1'b1;
                    if (version_hit)
                    begin
                        verdict = hrlc_pkg::VERDICT_OK;
                        ver_out = version_code;
                    end
                    else
                    begin
                        verdict = hrlc_pkg::VERDICT_BAD_REQ;
                    end
                end
                else
                begin
                    vchars_next = {vchars_reg[hrlc_pkg::VERSION_BUF_W-9:0], item.byte_in};
                    vcount_next = vcount_reg + 1'b1;
                end
            end
            default:
            begin
                // verdict already out, wait for the last byte
            end
        endcase

        if (give)
        begin
            phase_next = hrlc_pkg::PH_DONE;
        end

        // request ended before a verdict
        if (item.last_byte && phase_reg != hrlc_pkg::PH_DONE && !give)
        begin
            give    = 1'b1;
            verdict = (phase_next == hrlc_pkg::PH_METHOD) ?
                      hrlc_pkg::VERDICT_BAD_METHOD : hrlc_pkg::VERDICT_BAD_REQ;
        end

        method_bad       = (verdict == hrlc_pkg::VERDICT_BAD_METHOD);
        res.verdict      = verdict;
        res.method_code  = method_bad ? 4'd0 : found_next;
        res.version_code = ver_out;
        res.url_len      = method_bad ? 16'd0 : 16'(url_next);
        res.url_too_long = !method_bad && (url_next == URL_MAX);

        // last byte rearms the parser
        if (item.last_byte)
        begin
            phase_next  = hrlc_pkg::PH_METHOD;
            mcount_next = '0;
            vcount_next = 3'd0;
            url_next    = '0;
            found_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hrlc_pkg::PH_METHOD;
            mcount_reg <= '0;
            vcount_reg <= 3'd0;
            url_reg    <= '0;
            found_reg  <= 4'd0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            mcount_reg <= mcount_next;
            vcount_reg <= vcount_next;
            url_reg    <= url_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mchars_reg <= mchars_next;
            vchars_reg <= vchars_next;
        end
    end

`ifndef ASSERT_OFF
    a_quiet_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == hrlc_pkg::PH_DONE) |-> !give)
        else $error("result produced after verdict");

    a_ok_only_from_version: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && give && verdict == hrlc_pkg::VERDICT_OK) |->
        (phase_reg == hrlc_pkg::PH_VERSION))
        else $error("ok verdict outside version phase");

    a_bad_method_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (give && verdict == hrlc_pkg::VERDICT_BAD_METHOD) |->
        (res.method_code == 4'd0 && res.url_len == 16'd0 && !res.url_too_long))
        else $error("bad method result carries fields");

    a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.last_byte) |=>
        (phase_reg == hrlc_pkg::PH_METHOD && mcount_reg == '0 && url_reg == '0))
        else $error("last byte did not rearm parser");
`endif

endmodule

[rtl/core/hrlc_out_stage.sv]
// result register toward the output stream
// depends on hrlc_pkg

module hrlc_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  hrlc_pkg::result_t   res,
    output logic                room,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata
);

    logic              valid_reg;
    hrlc_pkg::result_t res_reg;

    assign room = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, res_reg};

endmodule

[rtl/core/http_request_line_checker.sv]
// top level of the http request line checker
// depends on hrlc_pkg, hrlc_in_stage, hrlc_parse, hrlc_out_stage

// Checks the request line of an http request arriving one byte per item on
// the s_ stream and returns one verdict per request on the m_ stream: ok,
// unsupported or malformed method (GET HEAD POST PUT DELETE CONNECT OPTIONS
// TRACE PATCH, method checked first), or bad request line / version
// (HTTP/1.1, HTTP/1.0, HTTP/0.9). The verdict also carries the method code,
// version code and url byte count, which saturates with a flag. After a
// verdict, bytes are dropped until an item with tlast set, which rearms the
// parser; tlast before a verdict forces one. The block takes one byte per
// cycle while the result register can take it: a byte is registered on
// entry, and the parser state and result register update when it moves on
// from the input register, so a verdict passes the input register and then
// the result register before it shows on m_tvalid. A stalled result
// register holds the parser, and that backs up into the input register.
// There is no clearing pass after reset.

module http_request_line_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] byte_in
    input  logic         s_tlast,    // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata     // [1:0] verdict, [5:2] method_code,
                                     // [7:6] version_code, [23:8] url byte count,
                                     // [24] url_too_long, rest zero
);

    logic              item_valid;
    hrlc_pkg::item_t   item;
    logic              room;
    logic              fire;
    logic              give;
    hrlc_pkg::result_t res;

    // byte moves into the parser only when the result register can take it
    assign fire = item_valid && room;

    hrlc_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    hrlc_parse u_parse
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .give  (give),
        .res   (res)
    );

    hrlc_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && give),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
